/* hw/rtl/grwd_pkg.sv */
// Package for the grid ray wall distance unit: map geometry, fixed-point widths,
// sine polynomial coefficients and the opcode names.
// Has no dependencies; the top level imports it.
package grwd_pkg;

	localparam int MAP_COLS  = 64;
	localparam int MAP_ROWS  = 64;
	localparam int COL_W     = 6;
	localparam int ROW_W     = 6;
	localparam int ADDR_W    = COL_W + ROW_W;
	localparam int FRAC_BITS = 8;
	localparam int POS_W     = 14;
	localparam int ANGLE_W   = 12;
	localparam int QUAD_W    = ANGLE_W - 2;
	localparam int DIST_W    = 16;
	localparam int HIT_W     = 7;

	// Q30 trig values, their products, and the Q16 ray parameters.
	localparam int Q30_W   = 31;
	localparam int PROD_W  = 2 * Q30_W;
	localparam int D_W     = FRAC_BITS + 1;
	localparam int NUM_W   = 47;
	localparam int QUO_W   = 27;
	localparam int RAY_W   = 35;
	localparam int DCNT_W  = 5;

	localparam logic [Q30_W-1:0] Q30_ONE = Q30_W'(1) << 30;
	localparam logic [Q30_W-1:0] C1 = 31'd1686629713;
	localparam logic [Q30_W-1:0] C3 = 31'd693598668;
	localparam logic [Q30_W-1:0] C5 = 31'd85569306;
	localparam logic [Q30_W-1:0] C7 = 31'd5026995;
	localparam logic [Q30_W-1:0] C9 = 31'd172272;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_CAST  = 1'b1;

	typedef logic [RAY_W-1:0] ray_t;

	// Horner step constants: the subtracted coefficient for polynomial steps 1 to 4.
	function automatic logic [Q30_W-1:0] horner_coef(input logic [2:0] k);
		logic [Q30_W-1:0] c;
		case (k)
			3'd1:    c = C7;
			3'd2:    c = C5;
			3'd3:    c = C3;
			default: c = C1;
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/grid_ray_wall_distance_unit.sv */
// Grid ray wall distance unit: one-bit wall map plus a ray caster that steps the
// ray cell by cell with a shared multiplier, a shared divider and one map port.
// Depends on grwd_pkg.
//
// Usage: one input channel (in_valid/in_ready) carries either a map write
// (op = 0) or a ray cast (op = 1). A write sets one map cell in the cycle of its
// transfer and produces no result. A cast produces exactly one result on the
// output channel (out_valid/out_ready): the Q8.8 distance to the entry of the
// stop cell, that cell, and whether it is a wall or the map edge.
// Steps of a cast, from its transfer to the result being offered:
//   sine and cosine evaluation (6 multiplies each on the shared multiplier),
//   a setup state, up to 4 divisions on the shared radix-2 divider, then a
//   map read and a step for each cell visited, and a finish state that loads
//   the result.
// The input is not ready while a cast is in progress; a write keeps it ready.
// After reset the map is cleared by a pass over all 4096 cells, one cell per cycle,
// during which no input is accepted. A finished result waits in the output
// register; a new item may be accepted meanwhile, but the next cast cannot
// deliver until the previous result has been taken.
module grid_ray_wall_distance_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [grwd_pkg::COL_W-1:0]    cell_col,
	input  logic [grwd_pkg::ROW_W-1:0]    cell_row,
	input  logic                          wall_bit,
	input  logic [grwd_pkg::POS_W-1:0]    start_col_pos,
	input  logic [grwd_pkg::POS_W-1:0]    start_row_pos,
	input  logic [grwd_pkg::ANGLE_W-1:0]  heading,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [grwd_pkg::DIST_W-1:0]   distance,
	output logic [grwd_pkg::HIT_W-1:0]    hit_col,
	output logic [grwd_pkg::HIT_W-1:0]    hit_row,
	output logic                          hit_is_wall
);
	import grwd_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TRIG,
		ST_SETUP,
		ST_DIV_LD,
		ST_DIV,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_FINISH
	} state_t;

	state_t state_q;

	logic [ADDR_W-1:0]  clr_q;
	logic [POS_W-1:0]   px_q, py_q;
	logic [ANGLE_W-1:0] h_q;

	// Sine/cosine evaluation.
	logic [2:0]        k_q;
	logic              ph_q, sel_q;
	logic [Q30_W-1:0]  x_q, x2_q, t_q, sa_q, ca_q;
	logic [PROD_W-1:0] prod_q;
	logic [Q30_W-1:0]  mul_a, mul_b, prod_sh;
	logic [Q30_W-1:0]  f_val;
	logic              rem_zero;

	// Ray setup.
	logic [Q30_W-1:0] mx_q, my_q;
	logic             negx_q, negy_q;
	logic [D_W-1:0]   dxd_q, dyd_q;

	// Divider.
	logic [1:0]        job_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [Q30_W-1:0]  drem_q;
	logic [QUO_W-1:0]  dnum_q;
	logic [Q30_W-1:0]  div_m;
	logic [D_W-1:0]    div_d;
	logic [NUM_W-1:0]  div_num;
	logic [Q30_W:0]    div_trial;
	logic              div_ge;
	logic [QUO_W-1:0]  div_quo;

	// Walk.
	ray_t             tx_q, ty_q, dx_q, dy_q, entry_q;
	logic [HIT_W-1:0] col_q, row_q;
	logic             wall_q;
	logic             at_edge;
	logic             step_col;
	logic [RAY_W-FRAC_BITS-1:0] ent_sh;

	// Map memory.
	logic              map_mem [MAP_COLS*MAP_ROWS];
	logic              mem_we, mem_wd, mem_rd_q;
	logic [ADDR_W-1:0] mem_wa, mem_ra;

	logic out_valid_q;
	logic in_xfer;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_valid = out_valid_q;

	assign f_val    = {1'b0, h_q[QUAD_W-1:0], 20'b0};
	assign rem_zero = (h_q[QUAD_W-1:0] == '0);

	always_comb begin
		case (k_q)
			3'd0: begin
				mul_a = x_q;
				mul_b = x_q;
			end
			3'd1: begin
				mul_a = x2_q;
				mul_b = C9;
			end
			3'd5: begin
				mul_a = x_q;
				mul_b = t_q;
			end
			default: begin
				mul_a = x2_q;
				mul_b = t_q;
			end
		endcase
	end

	assign prod_sh = prod_q[PROD_W-2:30];

	// Divider operands: jobs are first column crossing, column delta, first row
	// crossing, row delta. The dividend is the boundary distance shifted up 38.
	assign div_m     = job_q[1] ? my_q : mx_q;
	assign div_d     = job_q[0] ? D_W'(1 << FRAC_BITS) : (job_q[1] ? dyd_q : dxd_q);
	assign div_num   = {div_d, (NUM_W-D_W)'(0)};
	assign div_trial = {drem_q, dnum_q[QUO_W-1]};
	assign div_ge    = (div_trial >= {1'b0, div_m});
	assign div_quo   = {dnum_q[QUO_W-2:0], div_ge};

	assign at_edge  = (col_q == '0) || (col_q >= HIT_W'(MAP_COLS)) ||
	                  (row_q == '0) || (row_q >= HIT_W'(MAP_ROWS));
	assign step_col = (mx_q != '0) && ((my_q == '0) || (tx_q < ty_q));
	assign ent_sh   = entry_q[RAY_W-1:FRAC_BITS];

	assign mem_we = (state_q == ST_CLEAR) || (in_xfer && (op == OP_WRITE));
	assign mem_wa = (state_q == ST_CLEAR) ? clr_q : {cell_row, cell_col};
	assign mem_wd = (state_q == ST_CLEAR) ? 1'b0 : wall_bit;
	assign mem_ra = {row_q[ROW_W-1:0], col_q[COL_W-1:0]};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_wa] <= mem_wd;
		end
		mem_rd_q <= map_mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			px_q        <= '0;
			py_q        <= '0;
			h_q         <= '0;
			k_q         <= '0;
			ph_q        <= 1'b0;
			sel_q       <= 1'b0;
			x_q         <= '0;
			x2_q        <= '0;
			t_q         <= '0;
			sa_q        <= '0;
			ca_q        <= '0;
			prod_q      <= '0;
			mx_q        <= '0;
			my_q        <= '0;
			negx_q      <= 1'b0;
			negy_q      <= 1'b0;
			dxd_q       <= '0;
			dyd_q       <= '0;
			job_q       <= '0;
			dcnt_q      <= '0;
			drem_q      <= '0;
			dnum_q      <= '0;
			tx_q        <= '0;
			ty_q        <= '0;
			dx_q        <= '0;
			dy_q        <= '0;
			entry_q     <= '0;
			col_q       <= '0;
			row_q       <= '0;
			wall_q      <= 1'b0;
			out_valid_q <= 1'b0;
			distance    <= '0;
			hit_col     <= '0;
			hit_row     <= '0;
			hit_is_wall <= 1'b0;
		end else begin
			// In the finish state the output register is reloaded instead.
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_xfer && (op == OP_CAST)) begin
						px_q    <= start_col_pos;
						py_q    <= start_row_pos;
						h_q     <= heading;
						x_q     <= {1'b0, heading[QUAD_W-1:0], 20'b0};
						k_q     <= '0;
						ph_q    <= 1'b0;
						sel_q   <= 1'b0;
						state_q <= ST_TRIG;
					end
				end
				ST_TRIG: begin
					if (!ph_q) begin
						prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
						ph_q   <= 1'b1;
					end else begin
						ph_q <= 1'b0;
						k_q  <= (k_q == 3'd5) ? 3'd0 : k_q + 1'b1;
						case (k_q)
							3'd0: x2_q <= prod_sh;
							3'd5: begin
								if (!sel_q) begin
									sa_q  <= prod_sh;
									x_q   <= Q30_ONE - f_val;
									sel_q <= 1'b1;
								end else begin
									ca_q    <= prod_sh;
									state_q <= ST_SETUP;
								end
							end
							default: t_q <= horner_coef(k_q) - prod_sh;
						endcase
					end
				end
				ST_SETUP: begin
					// Odd quadrants swap the components; an axis-aligned ray has an
					// exactly zero component, which then never steps.
					if (h_q[QUAD_W]) begin
						mx_q <= rem_zero ? '0 : sa_q;
						my_q <= rem_zero ? Q30_ONE : ca_q;
					end else begin
						mx_q <= rem_zero ? Q30_ONE : ca_q;
						my_q <= rem_zero ? '0 : sa_q;
					end
					negx_q <= h_q[ANGLE_W-1] ^ h_q[ANGLE_W-2];
					negy_q <= h_q[ANGLE_W-1];
					dxd_q  <= (h_q[ANGLE_W-1] ^ h_q[ANGLE_W-2]) ?
					          D_W'(px_q[FRAC_BITS-1:0]) :
					          D_W'(1 << FRAC_BITS) - D_W'(px_q[FRAC_BITS-1:0]);
					dyd_q  <= h_q[ANGLE_W-1] ?
					          D_W'(py_q[FRAC_BITS-1:0]) :
					          D_W'(1 << FRAC_BITS) - D_W'(py_q[FRAC_BITS-1:0]);
					job_q   <= '0;
					state_q <= ST_DIV_LD;
				end
				ST_DIV_LD: begin
					if (div_m == '0) begin
						case (job_q)
							2'd0:    tx_q <= '0;
							2'd1:    dx_q <= '0;
							2'd2:    ty_q <= '0;
							default: dy_q <= '0;
						endcase
						job_q <= job_q + 1'b1;
						if (job_q == 2'd3) begin
							col_q   <= HIT_W'(px_q[POS_W-1:FRAC_BITS]);
							row_q   <= HIT_W'(py_q[POS_W-1:FRAC_BITS]);
							entry_q <= '0;
							state_q <= ST_WALK_RD;
						end
					end else begin
						// The upper dividend bits are below the divisor, so the
						// quotient fits in QUO_W bits.
						drem_q  <= Q30_W'(div_num[NUM_W-1:QUO_W]);
						dnum_q  <= div_num[QUO_W-1:0];
						dcnt_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					drem_q <= div_ge ? Q30_W'(div_trial - {1'b0, div_m}) : Q30_W'(div_trial);
					dnum_q <= div_quo;
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_W'(QUO_W - 1)) begin
						case (job_q)
							2'd0:    tx_q <= RAY_W'(div_quo);
							2'd1:    dx_q <= RAY_W'(div_quo);
							2'd2:    ty_q <= RAY_W'(div_quo);
							default: dy_q <= RAY_W'(div_quo);
						endcase
						job_q <= job_q + 1'b1;
						if (job_q == 2'd3) begin
							col_q   <= HIT_W'(px_q[POS_W-1:FRAC_BITS]);
							row_q   <= HIT_W'(py_q[POS_W-1:FRAC_BITS]);
							entry_q <= '0;
							state_q <= ST_WALK_RD;
						end else begin
							state_q <= ST_DIV_LD;
						end
					end
				end
				ST_WALK_RD: begin
					if (at_edge) begin
						wall_q  <= 1'b0;
						state_q <= ST_FINISH;
					end else begin
						state_q <= ST_WALK_EV;
					end
				end
				ST_WALK_EV: begin
					if (mem_rd_q) begin
						wall_q  <= 1'b1;
						state_q <= ST_FINISH;
					end else begin
						// On a tie the row axis steps.
						if (step_col) begin
							entry_q <= tx_q;
							tx_q    <= tx_q + dx_q;
							col_q   <= negx_q ? col_q - 1'b1 : col_q + 1'b1;
						end else begin
							entry_q <= ty_q;
							ty_q    <= ty_q + dy_q;
							row_q   <= negy_q ? row_q - 1'b1 : row_q + 1'b1;
						end
						state_q <= ST_WALK_RD;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						distance    <= (|ent_sh[RAY_W-FRAC_BITS-1:DIST_W]) ?
						               '1 : ent_sh[DIST_W-1:0];
						hit_col     <= col_q;
						hit_row     <= row_q;
						hit_is_wall <= wall_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// A wall result always names a cell inside the map.
	a_wall_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && hit_is_wall |->
			(hit_col != '0) && (hit_col < HIT_W'(MAP_COLS)) &&
			(hit_row != '0) && (hit_row < HIT_W'(MAP_ROWS)))
		else $error("wall result outside the map");

	// An edge result always names an edge cell.
	a_edge_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !hit_is_wall |->
			(hit_col == '0) || (hit_col >= HIT_W'(MAP_COLS)) ||
			(hit_row == '0) || (hit_row >= HIT_W'(MAP_ROWS)))
		else $error("edge result inside the map");

	// The divider remainder stays below the divisor.
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (drem_q < div_m))
		else $error("divider remainder out of range");

	// No result appears and no input is accepted while the map is being cleared.
	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid_q && !in_ready)
		else $error("activity during the map clearing pass");

endmodule

/* test/ray_cast_checker.sv */
// Checker for the grid ray wall distance unit: mirrors the wall map, predicts
// every cast from the transfers it sees, and compares the results in order.
// Depends on grwd_pkg.
module ray_cast_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          op,
	input  logic [grwd_pkg::COL_W-1:0]    cell_col,
	input  logic [grwd_pkg::ROW_W-1:0]    cell_row,
	input  logic                          wall_bit,
	input  logic [grwd_pkg::POS_W-1:0]    start_col_pos,
	input  logic [grwd_pkg::POS_W-1:0]    start_row_pos,
	input  logic [grwd_pkg::ANGLE_W-1:0]  heading,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [grwd_pkg::DIST_W-1:0]   distance,
	input  logic [grwd_pkg::HIT_W-1:0]    hit_col,
	input  logic [grwd_pkg::HIT_W-1:0]    hit_row,
	input  logic                          hit_is_wall,
	output int                            mismatch_count,
	output int                            casts_in_flight
);
	timeunit 1ns;
	timeprecision 1ps;
	import grwd_pkg::*;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic [HIT_W-1:0]  col;
		logic [HIT_W-1:0]  row;
		logic              wall;
	} ray_hit_t;

	ray_hit_t hits_due[$];
	bit       wall_cells [MAP_ROWS][MAP_COLS];

	// sin(x * pi/2) for x in Q30 over [0, 1], odd polynomial evaluated by Horner.
	function automatic longint unsigned quarter_sine(input longint unsigned x);
		longint unsigned x2, t;
		x2 = (x * x) >> 30;
		t = C9;
		t = C7 - ((x2 * t) >> 30);
		t = C5 - ((x2 * t) >> 30);
		t = C3 - ((x2 * t) >> 30);
		t = C1 - ((x2 * t) >> 30);
		return (x * t) >> 30;
	endfunction

	// First boundary crossing and per-cell increment along one axis, both Q16.
	function automatic void crossing_setup(input logic [POS_W-1:0] pos, input int dir,
			input longint unsigned mag, output longint unsigned first,
			output longint unsigned gap);
		longint unsigned part;
		part = pos[FRAC_BITS-1:0];
		if (dir == 0 || mag == 0) begin
			first = 0;
			gap = 0;
			return;
		end
		if (dir > 0)
			part = (64'd1 << FRAC_BITS) - part;
		first = (part << (46 - FRAC_BITS)) / mag;
		gap = (64'd1 << 46) / mag;
	endfunction

	function automatic bit cell_is_open(input longint c, input longint r);
		if (c <= 0 || c >= MAP_COLS || r <= 0 || r >= MAP_ROWS)
			return 1'b0;
		return !wall_cells[r][c];
	endfunction

	function automatic ray_hit_t trace_ray(input logic [POS_W-1:0] pcol,
			input logic [POS_W-1:0] prow, input logic [ANGLE_W-1:0] hd);
		longint unsigned rem, frac, sn, cs, mag_c, mag_r;
		longint unsigned next_c, next_r, gap_c, gap_r, entry, scaled;
		int       dir_c, dir_r;
		longint   c, r;
		ray_hit_t res;
		rem = longint'(hd[QUAD_W-1:0]) << 2;
		frac = (rem << 30) >> ANGLE_W;
		if (rem == 0) begin
			sn = 0;
			cs = Q30_ONE;
		end else begin
			sn = quarter_sine(frac);
			cs = quarter_sine(Q30_ONE - frac);
		end
		// An axis-aligned heading has no motion at all along the other axis.
		case (hd[ANGLE_W-1 -: 2])
			2'd0: begin
				dir_c = 1;
				dir_r = (rem != 0) ? 1 : 0;
				mag_c = cs;
				mag_r = sn;
			end
			2'd1: begin
				dir_c = (rem != 0) ? -1 : 0;
				dir_r = 1;
				mag_c = sn;
				mag_r = cs;
			end
			2'd2: begin
				dir_c = -1;
				dir_r = (rem != 0) ? -1 : 0;
				mag_c = cs;
				mag_r = sn;
			end
			default: begin
				dir_c = (rem != 0) ? 1 : 0;
				dir_r = -1;
				mag_c = sn;
				mag_r = cs;
			end
		endcase
		crossing_setup(pcol, dir_c, mag_c, next_c, gap_c);
		crossing_setup(prow, dir_r, mag_r, next_r, gap_r);
		if (mag_c == 0)
			dir_c = 0;
		if (mag_r == 0)
			dir_r = 0;
		c = pcol >> FRAC_BITS;
		r = prow >> FRAC_BITS;
		entry = 0;
		// On equal crossings the row axis takes the step.
		while (cell_is_open(c, r)) begin
			if (dir_c != 0 && (dir_r == 0 || next_c < next_r)) begin
				entry = next_c;
				next_c += gap_c;
				c += dir_c;
			end else begin
				entry = next_r;
				next_r += gap_r;
				r += dir_r;
			end
		end
		scaled = entry >> (16 - FRAC_BITS);
		if (scaled > 64'hFFFF)
			scaled = 64'hFFFF;
		res.distance = scaled[DIST_W-1:0];
		res.col = c[HIT_W-1:0];
		res.row = r[HIT_W-1:0];
		res.wall = (c > 0 && c < MAP_COLS && r > 0 && r < MAP_ROWS);
		return res;
	endfunction

	function automatic bit field_differs(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want === got)
			return 1'b0;
		$display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		ray_hit_t want;
		bit       bad;
		if (!arst_n) begin
			hits_due.delete();
			mismatch_count = 0;
			foreach (wall_cells[r, c])
				wall_cells[r][c] = 1'b0;
		end else begin
			// Results are taken before new casts so that a cast accepted at the same
			// edge can never be matched against an earlier result.
			if (out_valid && out_ready) begin
				if (hits_due.size() == 0) begin
					$display("%0t: result without a pending cast: distance %0d col %0d row %0d wall %0d",
						$time, distance, hit_col, hit_row, hit_is_wall);
					mismatch_count++;
				end else begin
					want = hits_due.pop_front();
					bad = field_differs("distance", want.distance, distance)
						| field_differs("hit_col", want.col, hit_col)
						| field_differs("hit_row", want.row, hit_row)
						| field_differs("hit_is_wall", want.wall, hit_is_wall);
					if (bad)
						mismatch_count++;
				end
			end
			if (in_valid && in_ready) begin
				if (op == OP_WRITE)
					wall_cells[cell_row][cell_col] = wall_bit;
				else
					hits_due.push_back(trace_ray(start_col_pos, start_row_pos, heading));
			end
		end
		casts_in_flight = hits_due.size();
	end

endmodule

/* test/tb.sv */
// Top of the testbench for the grid ray wall distance unit: clock, reset, map
// writes and ray casts with random gaps, and the verdict.
// Depends on grwd_pkg, grid_ray_wall_distance_unit and ray_cast_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import grwd_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic                op;
	logic [COL_W-1:0]    cell_col;
	logic [ROW_W-1:0]    cell_row;
	logic                wall_bit;
	logic [POS_W-1:0]    start_col_pos;
	logic [POS_W-1:0]    start_row_pos;
	logic [ANGLE_W-1:0]  heading;
	logic                out_valid;
	logic                out_ready;
	logic [DIST_W-1:0]   distance;
	logic [HIT_W-1:0]    hit_col;
	logic [HIT_W-1:0]    hit_row;
	logic                hit_is_wall;
	int                  mismatch_count;
	int                  casts_in_flight;
	bit                  steady;

	grid_ray_wall_distance_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .cell_col(cell_col), .cell_row(cell_row), .wall_bit(wall_bit),
		.start_col_pos(start_col_pos), .start_row_pos(start_row_pos), .heading(heading),
		.out_valid(out_valid), .out_ready(out_ready),
		.distance(distance), .hit_col(hit_col), .hit_row(hit_row),
		.hit_is_wall(hit_is_wall)
	);

	ray_cast_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .cell_col(cell_col), .cell_row(cell_row), .wall_bit(wall_bit),
		.start_col_pos(start_col_pos), .start_row_pos(start_row_pos), .heading(heading),
		.out_valid(out_valid), .out_ready(out_ready),
		.distance(distance), .hit_col(hit_col), .hit_row(hit_row),
		.hit_is_wall(hit_is_wall),
		.mismatch_count(mismatch_count), .casts_in_flight(casts_in_flight)
	);

	always #4 clk = ~clk;

	always @(negedge clk)
		out_ready <= steady || ($urandom_range(0, 99) >= 34);

	initial begin
		#32_000_000;
		$display("status: fail");
		$finish;
	end

	// Called right after a rising edge; returns at the edge where the transfer
	// happens. Valid goes high only once the random gap is over.
	task automatic offer(input logic o, input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
			input logic w, input logic [POS_W-1:0] pc, input logic [POS_W-1:0] pr,
			input logic [ANGLE_W-1:0] h);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		cell_col <= c;
		cell_row <= r;
		wall_bit <= w;
		start_col_pos <= pc;
		start_row_pos <= pr;
		heading <= h;
		do @(posedge clk); while (!in_ready);
	endtask

	// The fields a write or cast does not use carry random values.
	task automatic map_write(input logic [COL_W-1:0] c, input logic [ROW_W-1:0] r,
			input logic w);
		offer(OP_WRITE, c, r, w, POS_W'($urandom()), POS_W'($urandom()),
			ANGLE_W'($urandom()));
	endtask

	task automatic cast_ray(input logic [POS_W-1:0] pc, input logic [POS_W-1:0] pr,
			input logic [ANGLE_W-1:0] h);
		offer(OP_CAST, COL_W'($urandom()), ROW_W'($urandom()), 1'($urandom()), pc, pr, h);
	endtask

	// Start cell within [lo, hi] on both axes; fractions and headings lean toward
	// cell boundaries, axis directions, diagonals and near-axis angles.
	task automatic random_cast(input int lo, input int hi);
		logic [POS_W-1:0]   pc, pr;
		logic [ANGLE_W-1:0] h;
		int                 mode;
		pc = {6'($urandom_range(lo, hi)), 8'($urandom())};
		pr = {6'($urandom_range(lo, hi)), 8'($urandom())};
		mode = $urandom_range(0, 9);
		if (mode == 0) begin
			pc[FRAC_BITS-1:0] = '0;
			pr[FRAC_BITS-1:0] = '0;
		end else if (mode == 1) begin
			pc[FRAC_BITS-1:0] = '1;
			pr[FRAC_BITS-1:0] = 8'h80;
		end else if (mode == 2) begin
			pr[FRAC_BITS-1:0] = pc[FRAC_BITS-1:0];
		end
		h = ANGLE_W'($urandom());
		mode = $urandom_range(0, 9);
		if (mode == 7)
			h[QUAD_W-1:0] = '0;
		else if (mode == 8)
			h[QUAD_W-1:0] = 10'd512;
		else if (mode == 9)
			h[QUAD_W-1:0] = $urandom_range(0, 1) ? 10'($urandom_range(1, 3))
				: 10'($urandom_range(1021, 1023));
		cast_ray(pc, pr, h);
	endtask

	task automatic wait_drained;
		@(negedge clk);
		in_valid <= 1'b0;
		while (casts_in_flight != 0)
			@(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_WRITE;
		cell_col = '0;
		cell_row = '0;
		wall_bit = 1'b0;
		start_col_pos = '0;
		start_row_pos = '0;
		heading = '0;
		steady = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: corner and edge cells, axis headings in every quadrant, exact
		// diagonals from a cell center (row wins the ties), shallow angles, starts
		// on the edge and on a wall, and a wall placed and then removed.
		map_write(6'd63, 6'd63, 1'b1);
		map_write(6'd0, 6'd0, 1'b1);
		map_write(6'd0, 6'd0, 1'b0);
		cast_ray(14'h0A80, 14'h0A80, 12'd0);
		cast_ray(14'h0A80, 14'h0A80, 12'd1024);
		cast_ray(14'h0A80, 14'h0A80, 12'd2048);
		cast_ray(14'h0A80, 14'h0A80, 12'd3072);
		cast_ray(14'h0A80, 14'h0A80, 12'd512);
		cast_ray(14'h0A80, 14'h0A80, 12'd1536);
		cast_ray(14'h0A80, 14'h0A80, 12'd2560);
		cast_ray(14'h0A80, 14'h0A80, 12'd3584);
		cast_ray(14'h2000, 14'h1000, 12'd1);
		cast_ray(14'h2000, 14'h1000, 12'd4095);
		cast_ray(14'h0000, 14'h0000, 12'd700);
		cast_ray(14'h3FFF, 14'h3FFF, 12'd2500);
		map_write(6'd20, 6'd10, 1'b1);
		cast_ray(14'h0A80, 14'h0A80, 12'd0);
		cast_ray(14'h0A00, 14'h0A00, 12'd0);
		cast_ray(14'h0A00, 14'h0A00, 12'd2048);
		map_write(6'd20, 6'd10, 1'b0);
		cast_ray(14'h0A80, 14'h0A80, 12'd0);
		cast_ray(14'h0080, 14'h1F40, 12'd1024);
		cast_ray(14'h1F40, 14'h3F80, 12'd3000);
		wait_drained;

		// Open map with scattered walls: long rays.
		for (int n = 0; n < 350; n++) begin
			if ($urandom_range(0, 99) < 25)
				map_write(COL_W'($urandom()), ROW_W'($urandom()),
					$urandom_range(0, 99) < 60);
			else
				random_cast(0, 63);
		end
		// The sender holds off until every cast so far has delivered.
		wait_drained;

		// Dense block of rooms in the middle of the map, casts from inside it.
		for (int n = 0; n < 350; n++) begin
			steady = (n >= 100 && n < 250);
			if ($urandom_range(0, 99) < 45)
				map_write(COL_W'($urandom_range(16, 47)), ROW_W'($urandom_range(16, 47)),
					$urandom_range(0, 99) < 70);
			else
				random_cast(17, 46);
		end
		steady = 1'b0;
		wait_drained;

		// Walls mostly cleared again, anywhere on the map.
		for (int n = 0; n < 330; n++) begin
			if ($urandom_range(0, 99) < 35)
				map_write(COL_W'($urandom()), ROW_W'($urandom()),
					$urandom_range(0, 99) < 30);
			else
				random_cast(0, 63);
		end
		wait_drained;
		repeat (500) @(negedge clk);

		if (mismatch_count == 0 && casts_in_flight == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
